>>> hdl/stq_pkg.sv
// Shared types and constants of the sorted timer queue.
package stq_pkg;

	localparam int CMD_W   = 2;
	localparam int IDF_W   = 8;
	localparam int FRAME_W = 32;
	localparam int STAT_W  = 3;
	localparam int DROP_W  = 5;
	localparam logic [DROP_W-1:0] DROP_MAX = 5'd31;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_QUERY  = 2'd2,
		CMD_TICK   = 2'd3
	} cmd_e_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_NOTFOUND = 3'd2,
		ST_FIRED    = 3'd3,
		ST_DONE     = 3'd4
	} status_e_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RD,
		S_CMP,
		S_FIN
	} state_e_t;

	// compare unit result
	typedef struct packed {
		logic gt;     // entry frame after key
		logic eq;     // entry frame equals key
		logic id_eq;  // entry id equals search id
	} cmp_res_t;

	// one result transaction
	typedef struct packed {
		status_e_t         status;
		logic [IDF_W-1:0]  fired_id;
		logic              is_member;
		logic [DROP_W-1:0] dropped_count;
		logic              last;
	} res_t;

endpackage

>>> hdl/stq_if.sv
// Valid/ready channel interfaces for commands and results.
interface stq_cmd_if;
	logic                        valid;
	logic                        ready;
	logic [stq_pkg::CMD_W-1:0]   command;
	logic [stq_pkg::IDF_W-1:0]   timer_id;
	logic [stq_pkg::FRAME_W-1:0] due_frame;
	logic [stq_pkg::FRAME_W-1:0] now_frame;

	modport source(output valid, command, timer_id, due_frame, now_frame, input ready);
	modport sink(input valid, command, timer_id, due_frame, now_frame, output ready);
endinterface

interface stq_res_if;
	logic                       valid;
	logic                       ready;
	logic [stq_pkg::STAT_W-1:0] status;
	logic [stq_pkg::IDF_W-1:0]  fired_id;
	logic                       is_member;
	logic [stq_pkg::DROP_W-1:0] dropped_count;
	logic                       last;

	modport source(output valid, status, fired_id, is_member, dropped_count, last,
		input ready);
	modport sink(input valid, status, fired_id, is_member, dropped_count, last,
		output ready);
endinterface

>>> hdl/sorted_timer_queue_top.sv
// Sorted timer queue: top level with sequencer and entry memory.
//
//  channel  | dir | payload                                             | transaction
//  ---------+-----+-----------------------------------------------------+-----------------
//  cmd_ch   | in  | command, timer_id, due_frame, now_frame             | valid & ready
//  res_ch   | out | status, fired_id, is_member, dropped_count, last    | valid & ready
//
// A command makes one pass over the stored entries, reading each entry from
// memory, then comparing and writing it back, between an accept and a finish state.
// An insert into a full table or any command on an empty list skips the pass.
// The pass runs over the single memory port pair and the one compare unit.
// Reset clears only the state and the entry count; the memory needs no clearing pass.
// A stalled result output holds the sequencer only when it must emit
// (a fired entry or the closing result); cmd_ch.ready is high only in idle.
module sorted_timer_queue_top #(
	parameter int DEPTH   = 16,
	parameter int ID_BITS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	stq_cmd_if.sink   cmd_ch,
	stq_res_if.source res_ch
);

	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int IDF_W   = stq_pkg::IDF_W;
	localparam int FRAME_W = stq_pkg::FRAME_W;
	localparam int DROP_W  = stq_pkg::DROP_W;
	// stored id bits: the id field never carries more than IDF_W
	localparam int SID_W   = (ID_BITS < IDF_W) ? ID_BITS : IDF_W;

	// sequencer state
	stq_pkg::state_e_t state_q, state_d;
	stq_pkg::cmd_e_t   cmd_q, cmd_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;     // stored entries
	logic [CNT_W-1:0]  idx_q, idx_d;     // scan position
	logic [CNT_W-1:0]  pop_q, pop_d;     // entries popped by this tick
	logic [SID_W-1:0]  id_q, id_d;
	logic [FRAME_W-1:0] key_q, key_d;    // due frame or now frame
	// insert: new entry placed; remove/query: id found; tick: still popping
	logic              flag_q, flag_d;
	logic [DROP_W-1:0] drop_q, drop_d;
	logic [FRAME_W-1:0] carry_frame_q, carry_frame_d;
	logic [SID_W-1:0]  carry_id_q, carry_id_d;

	// entry memory, one write and one registered read per cycle
	logic [FRAME_W-1:0] mem_frame [DEPTH];
	logic [SID_W-1:0]   mem_id    [DEPTH];
	logic [FRAME_W-1:0] rd_frame_q;
	logic [SID_W-1:0]   rd_id_q;
	logic               mem_we, mem_re;
	logic [IDX_W-1:0]   mem_waddr, mem_raddr;
	logic [FRAME_W-1:0] mem_wframe;
	logic [SID_W-1:0]   mem_wid;

	stq_pkg::cmp_res_t cmp;
	logic              emit, slot_free;
	stq_pkg::res_t     emit_res;

	logic [CNT_W-1:0]  idx_next;
	logic [CNT_W-1:0]  wr_shift;         // tick compaction target
	logic [CNT_W-1:0]  wr_prev;          // remove compaction target

	assign cmd_ch.ready = state_q == stq_pkg::S_IDLE;
	assign idx_next     = idx_q + CNT_W'(1);
	assign wr_shift     = idx_q - pop_q;
	assign wr_prev      = idx_q - CNT_W'(1);
	assign mem_raddr    = idx_q[IDX_W-1:0];

	stq_cmp #(.ID_W(SID_W)) u_cmp (
		.frame (rd_frame_q),
		.key   (key_q),
		.id_a  (rd_id_q),
		.id_b  (id_q),
		.res   (cmp)
	);

	stq_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.emit      (emit),
		.emit_res  (emit_res),
		.slot_free (slot_free),
		.res_ch    (res_ch)
	);

	always_comb begin
		state_d       = state_q;
		cmd_d         = cmd_q;
		cnt_d         = cnt_q;
		idx_d         = idx_q;
		pop_d         = pop_q;
		id_d          = id_q;
		key_d         = key_q;
		flag_d        = flag_q;
		drop_d        = drop_q;
		carry_frame_d = carry_frame_q;
		carry_id_d    = carry_id_q;
		mem_we        = 1'b0;
		mem_re        = 1'b0;
		mem_waddr     = wr_shift[IDX_W-1:0];
		mem_wframe    = rd_frame_q;
		mem_wid       = rd_id_q;
		emit          = 1'b0;
		emit_res.status        = stq_pkg::ST_OK;
		emit_res.fired_id      = IDF_W'(id_q);
		emit_res.is_member     = 1'b0;
		emit_res.dropped_count = '0;
		emit_res.last          = 1'b1;

		case (state_q)
			stq_pkg::S_IDLE: begin
				if (cmd_ch.valid) begin
					cmd_d  = stq_pkg::cmd_e_t'(cmd_ch.command);
					id_d   = cmd_ch.timer_id[SID_W-1:0];
					key_d  = (cmd_ch.command == stq_pkg::CMD_TICK) ?
						cmd_ch.now_frame : cmd_ch.due_frame;
					idx_d  = '0;
					pop_d  = '0;
					drop_d = '0;
					flag_d = cmd_ch.command == stq_pkg::CMD_TICK;
					// full insert or empty list: nothing to scan
					if (cnt_q == '0 || (cmd_ch.command == stq_pkg::CMD_INSERT &&
						cnt_q == CNT_W'(DEPTH))) begin
						state_d = stq_pkg::S_FIN;
					end else begin
						state_d = stq_pkg::S_RD;
					end
				end
			end
			stq_pkg::S_RD: begin
				mem_re  = 1'b1;
				state_d = stq_pkg::S_CMP;
			end
			stq_pkg::S_CMP: begin
				logic adv;
				adv = 1'b1;
				case (cmd_q)
					stq_pkg::CMD_INSERT: begin
						if (flag_q) begin
							// ripple the carried entry up one slot
							mem_we        = 1'b1;
							mem_waddr     = mem_raddr;
							mem_wframe    = carry_frame_q;
							mem_wid       = carry_id_q;
							carry_frame_d = rd_frame_q;
							carry_id_d    = rd_id_q;
						end else if (cmp.gt) begin
							// first entry due later: new one goes here
							mem_we        = 1'b1;
							mem_waddr     = mem_raddr;
							mem_wframe    = key_q;
							mem_wid       = id_q;
							carry_frame_d = rd_frame_q;
							carry_id_d    = rd_id_q;
							flag_d        = 1'b1;
						end
					end
					stq_pkg::CMD_REMOVE, stq_pkg::CMD_QUERY: begin
						if (flag_q) begin
							if (cmd_q == stq_pkg::CMD_REMOVE) begin
								mem_we    = 1'b1;
								mem_waddr = wr_prev[IDX_W-1:0];
							end
						end else if (cmp.id_eq) begin
							flag_d = 1'b1;
						end
					end
					default: begin
						// tick
						if (flag_q && !cmp.gt) begin
							if (cmp.eq) begin
								emit_res.status   = stq_pkg::ST_FIRED;
								emit_res.fired_id = IDF_W'(rd_id_q);
								emit_res.last     = 1'b0;
								emit              = slot_free;
								adv               = slot_free;
							end else if (drop_q != stq_pkg::DROP_MAX) begin
								drop_d = drop_q + DROP_W'(1);
							end
							if (adv) begin
								pop_d = pop_q + CNT_W'(1);
							end
						end else begin
							// keep entry, moved down over the popped ones
							flag_d = 1'b0;
							mem_we = 1'b1;
						end
					end
				endcase
				if (adv) begin
					idx_d   = idx_next;
					state_d = (idx_next == cnt_q) ? stq_pkg::S_FIN : stq_pkg::S_RD;
				end
			end
			stq_pkg::S_FIN: begin
				case (cmd_q)
					stq_pkg::CMD_INSERT: begin
						if (cnt_q == CNT_W'(DEPTH)) begin
							emit_res.status = stq_pkg::ST_FULL;
						end else if (slot_free) begin
							mem_we     = 1'b1;
							mem_waddr  = cnt_q[IDX_W-1:0];
							mem_wframe = flag_q ? carry_frame_q : key_q;
							mem_wid    = flag_q ? carry_id_q : id_q;
							cnt_d      = cnt_q + CNT_W'(1);
						end
					end
					stq_pkg::CMD_REMOVE: begin
						if (!flag_q) begin
							emit_res.status = stq_pkg::ST_NOTFOUND;
						end else if (slot_free) begin
							cnt_d = cnt_q - CNT_W'(1);
						end
					end
					stq_pkg::CMD_QUERY: begin
						emit_res.is_member = flag_q;
					end
					default: begin
						emit_res.status        = stq_pkg::ST_DONE;
						emit_res.fired_id      = '0;
						emit_res.dropped_count = drop_q;
						if (slot_free) begin
							cnt_d = cnt_q - pop_q;
						end
					end
				endcase
				emit = slot_free;
				if (slot_free) begin
					state_d = stq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = stq_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stq_pkg::S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q         <= cmd_d;
		idx_q         <= idx_d;
		pop_q         <= pop_d;
		id_q          <= id_d;
		key_q         <= key_d;
		flag_q        <= flag_d;
		drop_q        <= drop_d;
		carry_frame_q <= carry_frame_d;
		carry_id_q    <= carry_id_d;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_frame[mem_waddr] <= mem_wframe;
			mem_id[mem_waddr]    <= mem_wid;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rd_frame_q <= mem_frame[mem_raddr];
			rd_id_q    <= mem_id[mem_raddr];
		end
	end

endmodule

>>> hdl/stq_cmp.sv
// Shared compare unit: entry frame against key, entry id against search id.
module stq_cmp #(
	parameter int ID_W = 8
) (
	input  logic [stq_pkg::FRAME_W-1:0] frame,
	input  logic [stq_pkg::FRAME_W-1:0] key,
	input  logic [ID_W-1:0]             id_a,
	input  logic [ID_W-1:0]             id_b,
	output stq_pkg::cmp_res_t           res
);

	always_comb begin
		res.gt    = frame > key;
		res.eq    = frame == key;
		res.id_eq = id_a == id_b;
	end

endmodule

>>> hdl/stq_out_reg.sv
// Result output register; frees the sequencer while a result waits.
module stq_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              emit,
	input  stq_pkg::res_t     emit_res,
	output logic              slot_free,
	stq_res_if.source         res_ch
);

	logic          out_valid_q;
	stq_pkg::res_t out_q;

	assign slot_free = !out_valid_q || res_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (res_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= emit_res;
		end
	end

	assign res_ch.valid         = out_valid_q;
	assign res_ch.status        = out_q.status;
	assign res_ch.fired_id      = out_q.fired_id;
	assign res_ch.is_member     = out_q.is_member;
	assign res_ch.dropped_count = out_q.dropped_count;
	assign res_ch.last          = out_q.last;

endmodule

>>> hdl/stq_checker.sv
// Port-level assertions for the sorted timer queue, bound to the top level.
module stq_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       cmd_valid,
	input logic                       cmd_ready,
	input logic                       res_valid,
	input logic                       res_ready,
	input logic [stq_pkg::STAT_W-1:0] res_status,
	input logic [stq_pkg::IDF_W-1:0]  res_fired_id,
	input logic                       res_is_member,
	input logic [stq_pkg::DROP_W-1:0] res_dropped,
	input logic                       res_last
);

	// stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid &&
		$stable({res_status, res_fired_id, res_is_member, res_dropped, res_last}))
		else $error("result changed while stalled");

	// ready drops once a command is accepted
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("ready high right after a command transaction");

	// fired results never close a command and carry no count or membership
	a_fired_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status == stq_pkg::ST_FIRED |->
		!res_last && res_dropped == '0 && !res_is_member)
		else $error("malformed fired result");

	// every other result is the closing one
	a_closing: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status != stq_pkg::ST_FIRED |-> res_last)
		else $error("non-fired result without last");

endmodule

bind sorted_timer_queue_top stq_checker u_stq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_valid     (cmd_ch.valid),
	.cmd_ready     (cmd_ch.ready),
	.res_valid     (res_ch.valid),
	.res_ready     (res_ch.ready),
	.res_status    (res_ch.status),
	.res_fired_id  (res_ch.fired_id),
	.res_is_member (res_ch.is_member),
	.res_dropped   (res_ch.dropped_count),
	.res_last      (res_ch.last)
);
